// ----- rtl/smmst_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the merge function for the slot statistics table
// no dependencies
package smmst_pkg;

	localparam int SLOTS      = 128;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int IDX_W      = 8;
	localparam int FUNC_W     = 2;
	localparam int CFG_W      = 8;
	localparam int STATS_W    = 3 * VALUE_BITS;
	localparam int IN_DATA_W  = ((IDX_W + STATS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((STATS_W + 7) / 8) * 8;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 8'd128;

	// func codes on the input tuser
	localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_QSLOT  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QTOTAL = 2'd2;

	typedef enum logic [1:0] {
		K_ADD,
		K_QSLOT,
		K_QTOTAL,
		K_QERR
	} kind_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] sum;
		logic [VALUE_BITS-1:0] lo;
		logic [VALUE_BITS-1:0] hi;
	} stats_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		stats_t            stats;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	function automatic stats_t stats_merge(stats_t a, stats_t b);
		stats_t r;
		r.hi  = ($signed(a.hi) < $signed(b.hi)) ? b.hi : a.hi;
		r.lo  = ($signed(b.lo) < $signed(a.lo)) ? b.lo : a.lo;
		r.sum = a.sum + b.sum;
		return r;
	endfunction

endpackage

// ----- rtl/slot_min_max_sum_table.sv -----
`timescale 1ns / 1ps
// Table of 128 statistics slots (max, min, wrapping sum) with a running total over all adds.
// The front end checks the one-based slot index against slots_in_use and classifies each
// word; a two-word queue feeds the back end, which reads the slot memory in its idle state
// and merges, writes or loads the result register in its exec state. A query stays in exec
// while the result register is held by m_tready low; the front end accepts one word a cycle
// until the queue is full. Adds with a bad index and func 3 are dropped without a result.
// Error results carry zero data. The slot valid marks and the valid mark of the total are
// cleared at reset, so no clearing pass is needed.
// depends on smmst_pkg, smmst_front, smmst_queue, smmst_back
module slot_min_max_sum_table import smmst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,    // slots_in_use
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,      // slot_index, new_max, new_min, new_sum
	input  logic [FUNC_W-1:0]     s_tuser,      // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,      // max_out, min_out, sum_out
	output logic                  m_tuser       // is_error
);

	q_status_t q_status;
	q_entry_t  q_push_entry;
	q_entry_t  q_head;
	logic      q_push;
	logic      q_pop;

	smmst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_entry   (q_push_entry)
	);

	smmst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.status     (q_status)
	);

	smmst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// error words never carry stale statistics
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error result with non-zero data");

	// back end only takes a word that is there
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// back end works on one word at a time
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back end popped twice in a row");

	// queue never overflows through the front end
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("push into full queue");

endmodule

// ----- rtl/smmst_front.sv -----
`timescale 1ns / 1ps
// front end: input handshake, slot count register, index check and classification
// depends on smmst_pkg
module smmst_front import smmst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [FUNC_W-1:0]     s_tuser,
	input  q_status_t             q_status,
	output logic                  q_push,
	output q_entry_t              q_entry
);

	logic [CFG_W-1:0] slots_in_use_q;
	logic [IDX_W-1:0] idx;
	logic             idx_ok;
	logic             keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= SLOTS_IN_USE_RESET;
		end else if (cfg_we) begin
			slots_in_use_q <= cfg_wdata;
		end
	end

	assign idx = s_tdata[IDX_W-1:0];

	// one-based index, limited by both the register and the table size
	assign idx_ok = (idx != '0) && (idx <= slots_in_use_q) && (32'(idx) <= 32'(SLOTS));

	always_comb begin
		q_entry.slot  = SLOT_W'(32'(idx) - 32'd1);
		q_entry.stats = s_tdata[IDX_W +: STATS_W];
		q_entry.kind  = K_ADD;
		keep          = 1'b0;
		unique case (s_tuser)
			FN_ADD: begin
				q_entry.kind = K_ADD;
				keep         = idx_ok;
			end
			FN_QSLOT: begin
				q_entry.kind = idx_ok ? K_QSLOT : K_QERR;
				keep         = 1'b1;
			end
			FN_QTOTAL: begin
				q_entry.kind = K_QTOTAL;
				keep         = 1'b1;
			end
			default: begin
				q_entry.kind = K_ADD;
				keep         = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_status.full;
	assign q_push   = s_tvalid && s_tready && keep;

endmodule

// ----- rtl/smmst_queue.sv -----
`timescale 1ns / 1ps
// short word queue between the front end and the back end
// depends on smmst_pkg
module smmst_queue import smmst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t status
);

	q_entry_t          buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.empty = (count_q == '0);
	assign status.full  = (32'(count_q) == QDEPTH);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/smmst_back.sv -----
`timescale 1ns / 1ps
// back end: slot memory, valid marks, running total and the result register
// depends on smmst_pkg
module smmst_back import smmst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_status_t             q_status,
	input  q_entry_t              q_head,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser
);

	back_state_t state_q, state_d;

	stats_t      mem [SLOTS];
	stats_t      rd_s1;
	q_entry_t    op_s1;

	logic [SLOTS-1:0] slot_valid_q;
	logic             total_valid_q;
	stats_t           total_q;

	logic   m_tvalid_q;
	logic   m_err_q;
	stats_t m_stats_q;

	logic   out_free;
	logic   do_add;
	logic   ld_out;
	logic   out_err;
	stats_t out_stats;
	stats_t slot_new;
	logic   is_query;

	assign out_free = !m_tvalid_q || m_tready;
	assign is_query = (op_s1.kind != K_ADD);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (!is_query || out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop  = 1'b0;
		do_add = 1'b0;
		ld_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = !q_status.empty;
			end
			BK_EXEC: begin
				do_add = !is_query;
				ld_out = is_query && out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// result selection, error words carry zero data
	always_comb begin
		out_err   = 1'b1;
		out_stats = '0;
		unique case (op_s1.kind)
			K_QSLOT: begin
				out_err   = !slot_valid_q[op_s1.slot];
				out_stats = slot_valid_q[op_s1.slot] ? rd_s1 : '0;
			end
			K_QTOTAL: begin
				out_err   = !total_valid_q;
				out_stats = total_valid_q ? total_q : '0;
			end
			default: begin
				out_err   = 1'b1;
				out_stats = '0;
			end
		endcase
	end

	assign slot_new = slot_valid_q[op_s1.slot] ? stats_merge(rd_s1, op_s1.stats) : op_s1.stats;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1 <= q_head;
			rd_s1 <= mem[q_head.slot];
		end
		if (do_add) begin
			mem[op_s1.slot] <= slot_new;
		end
	end

	always_ff @(posedge clk) begin
		if (do_add) begin
			total_q <= total_valid_q ? stats_merge(total_q, op_s1.stats) : op_s1.stats;
		end
		if (ld_out) begin
			m_err_q   <= out_err;
			m_stats_q <= out_stats;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			slot_valid_q  <= '0;
			total_valid_q <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_add) begin
				slot_valid_q[op_s1.slot] <= 1'b1;
				total_valid_q            <= 1'b1;
			end
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_err_q;
	assign m_tdata  = OUT_DATA_W'(m_stats_q);

endmodule
